// ===== rtl/dsp_pkg.sv =====
package dsp_pkg;

   localparam int unsigned CHAR_WIDTH  = 8;
   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned MONTH_WIDTH = 4;
   localparam int unsigned DAY_WIDTH   = 5;
   localparam int unsigned PROD_WIDTH  = VALUE_WIDTH + 4;

   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'd57;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;

   localparam logic [VALUE_WIDTH-1:0] MAG_CAP     = 32'h8000_0000;
   localparam logic [VALUE_WIDTH-1:0] MAG_MAX_POS = 32'h7FFF_FFFF;
   localparam logic [VALUE_WIDTH-1:0] MONTH_MAX   = 32'd12;
   localparam logic [VALUE_WIDTH-1:0] DAY_MAX     = 32'd31;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FORMAT = 2'd1,
      ST_MONTH  = 2'd2,
      ST_DAY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_YEAR  = 2'd0,
      PH_MONTH = 2'd1,
      PH_DAY   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      SG_NONE  = 2'd0,
      SG_MINUS = 2'd1,
      SG_PLUS  = 2'd2
   } sign_stage_type;

endpackage

// ===== rtl/dsp_req_if.sv =====
interface dsp_req_if;
   logic                            valid;
   logic                            ready;
   logic [dsp_pkg::CHAR_WIDTH-1:0]  char_code;
   logic                            last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== rtl/dsp_rsp_if.sv =====
interface dsp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   dsp_pkg::status_type                    status;
   logic signed [dsp_pkg::VALUE_WIDTH-1:0] year;
   logic [dsp_pkg::MONTH_WIDTH-1:0]        month;
   logic [dsp_pkg::DAY_WIDTH-1:0]          day;

   modport source (output valid, output status, output year, output month, output day,
                   input ready);
   modport sink   (input valid, input status, input year, input month, input day,
                   output ready);
endinterface

// ===== rtl/date_string_parser.sv =====
// Year-month-day token parser.
// req_ch carries one token byte per beat (char_code), with last_char set on the
// final byte. rsp_ch carries one beat per token, on its final byte: status
// (ok, format error, bad month, bad day), and year, month, day, which are zero
// unless the status is ok. Non-final bytes produce no response beat.
// A byte is taken into an input register on a req_ch beat; from there the
// parse state is updated from it and, for a final byte, the response is
// written to the output register. Throughput is one byte per cycle while no
// final byte waits on a stalled response, set by the single state update (a
// multiply by ten and add on the 32-bit magnitude) between the two registers.
// A stalled response holds the output register; non-final bytes keep flowing
// until a second final byte would need the output register, and then req_ch
// ready drops until the response beat is taken.
// Synchronous reset empties both registers and returns the parser to the
// start of a token (year, no sign, no digits).
module date_string_parser (
   input  logic     clock,
   input  logic     reset,
   dsp_req_if.sink  req_ch,
   dsp_rsp_if.source rsp_ch
);
   import dsp_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   logic [CHAR_WIDTH-1:0]  s1_char_ff;
   logic                   s1_last_ff;

   phase_type              phase_ff, phase_in;
   sign_stage_type         sign_ff, sign_in;
   logic                   seen_ff, seen_in;
   logic                   neg_ff, neg_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   ovf_ff, ovf_in;
   logic                   ferr_ff, ferr_in;
   logic [VALUE_WIDTH-1:0] year_ff, year_in;
   logic                   month_ok_ff, month_ok_in;
   logic [MONTH_WIDTH-1:0] month_ff, month_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0] rsp_year_ff, rsp_year_in;
   logic [MONTH_WIDTH-1:0] rsp_month_ff, rsp_month_in;
   logic [DAY_WIDTH-1:0]   rsp_day_ff, rsp_day_in;

   logic                   out_free;
   logic                   advance;
   logic                   is_digit;
   logic [PROD_WIDTH-1:0]  prod;
   logic                   sat;
   logic                   fin_ferr;
   logic                   day_ok;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign advance  = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ch.ready = !s1_valid_ff || advance;

   assign s1_valid_in = req_ch.valid || (s1_valid_ff && !advance);

   assign is_digit = (s1_char_ff >= CH_ZERO) && (s1_char_ff <= CH_NINE);
   assign prod = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1)
               + {{(PROD_WIDTH-CHAR_WIDTH){1'b0}}, s1_char_ff - CH_ZERO};
   assign sat  = prod > {4'd0, MAG_CAP};

   always_comb begin
      phase_in    = phase_ff;
      sign_in     = sign_ff;
      seen_in     = seen_ff;
      neg_in      = neg_ff;
      mag_in      = mag_ff;
      ovf_in      = ovf_ff;
      ferr_in     = ferr_ff;
      year_in     = year_ff;
      month_ok_in = month_ok_ff;
      month_in    = month_ff;
      if (!ferr_ff) begin
         priority if (is_digit) begin
            mag_in  = sat ? MAG_CAP : prod[VALUE_WIDTH-1:0];
            ovf_in  = ovf_ff || sat;
            seen_in = 1'b1;
         end else if (!seen_ff && sign_ff == SG_NONE && s1_char_ff == CH_MINUS) begin
            neg_in  = 1'b1;
            sign_in = SG_MINUS;
         end else if (!seen_ff && sign_ff != SG_PLUS && s1_char_ff == CH_PLUS) begin
            sign_in = SG_PLUS;
         end else if (seen_ff && s1_char_ff == CH_MINUS && phase_ff != PH_DAY) begin
            ferr_in = ovf_ff || (!neg_ff && mag_ff > MAG_MAX_POS);
            if (phase_ff == PH_YEAR) begin
               year_in  = neg_ff ? (~mag_ff + 32'd1) : mag_ff;
               phase_in = PH_MONTH;
            end else begin
               month_ok_in = !neg_ff && mag_ff >= 32'd1 && mag_ff <= MONTH_MAX;
               month_in    = mag_ff[MONTH_WIDTH-1:0];
               phase_in    = PH_DAY;
            end
            sign_in = SG_NONE;
            seen_in = 1'b0;
            neg_in  = 1'b0;
            mag_in  = '0;
            ovf_in  = 1'b0;
         end else begin
            ferr_in = 1'b1;
         end
      end
   end

   assign fin_ferr = ferr_in || phase_in != PH_DAY || ovf_in || !seen_in
                   || (!neg_in && mag_in > MAG_MAX_POS);
   assign day_ok   = !neg_in && mag_in >= 32'd1 && mag_in <= DAY_MAX;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         priority if (fin_ferr) begin
            rsp_status_in = ST_FORMAT;
         end else if (!month_ok_in) begin
            rsp_status_in = ST_MONTH;
         end else if (!day_ok) begin
            rsp_status_in = ST_DAY;
         end else begin
            rsp_status_in = ST_OK;
         end
         if (rsp_status_in == ST_OK) begin
            rsp_year_in  = year_in;
            rsp_month_in = month_in;
            rsp_day_in   = mag_in[DAY_WIDTH-1:0];
         end else begin
            rsp_year_in  = '0;
            rsp_month_in = '0;
            rsp_day_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_ch.ready) begin
         s1_char_ff <= req_ch.char_code;
         s1_last_ff <= req_ch.last_char;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && s1_last_ff)) begin
         phase_ff    <= PH_YEAR;
         sign_ff     <= SG_NONE;
         seen_ff     <= 1'b0;
         neg_ff      <= 1'b0;
         mag_ff      <= '0;
         ovf_ff      <= 1'b0;
         ferr_ff     <= 1'b0;
         year_ff     <= '0;
         month_ok_ff <= 1'b0;
         month_ff    <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         sign_ff     <= sign_in;
         seen_ff     <= seen_in;
         neg_ff      <= neg_in;
         mag_ff      <= mag_in;
         ovf_ff      <= ovf_in;
         ferr_ff     <= ferr_in;
         year_ff     <= year_in;
         month_ok_ff <= month_ok_in;
         month_ff    <= month_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.year   = rsp_year_ff;
   assign rsp_ch.month  = rsp_month_ff;
   assign rsp_ch.day    = rsp_day_ff;

endmodule

// ===== rtl/dsp_checker.sv =====
module dsp_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input dsp_pkg::status_type                    rsp_status,
   input logic signed [dsp_pkg::VALUE_WIDTH-1:0] rsp_year,
   input logic [dsp_pkg::MONTH_WIDTH-1:0]        rsp_month,
   input logic [dsp_pkg::DAY_WIDTH-1:0]          rsp_day
);
   import dsp_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_year)
         && $stable(rsp_month) && $stable(rsp_day))
      else $error("stalled response beat changed");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_year == 0 && rsp_month == 0 && rsp_day == 0)
      else $error("error response carries a date");

   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OK |-> rsp_month >= 4'd1 && rsp_month <= 4'd12
         && rsp_day >= 5'd1)
      else $error("ok response with date out of range");

endmodule

bind date_string_parser dsp_checker u_dsp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_year   (rsp_ch.year),
   .rsp_month  (rsp_ch.month),
   .rsp_day    (rsp_ch.day)
);
